>>> hdl/lpff_pkg.sv
// Package for the length-prefixed fragment framer.
// Holds the item structs, the controller/datapath command and status structs and
// the width constants. No dependencies.
`default_nettype none

package lpff_pkg;

   localparam int unsigned LPFF_DATA_W  = 8;
   localparam int unsigned LPFF_COUNT_W = 6;
   localparam int unsigned LPFF_HDR_W   = 2;
   localparam int unsigned LPFF_WORD_W  = 32;

   typedef struct packed {
      logic [LPFF_DATA_W-1:0] data_byte;
      logic                   message_last;
   } lpff_req_type;

   typedef struct packed {
      logic [LPFF_DATA_W-1:0] out_byte;
      logic                   is_header;
      logic                   fragment_end;
      logic                   message_end;
   } lpff_rsp_type;

   typedef struct packed {
      logic wr;
      logic emit;
      logic hdr_load;
      logic pay_load;
   } lpff_cmd_type;

   typedef struct packed {
      logic full;
      logic hdr_last;
      logic pay_last;
      logic out_free;
   } lpff_sts_type;

endpackage

`default_nettype wire

>>> hdl/lpff_datapath.sv
// Datapath of the framer: fragment buffer memory, fill/read counters,
// header word and the output item register.
// Depends on lpff_pkg.
`default_nettype none

module lpff_datapath #(
   parameter int unsigned FRAGMENT_BYTES = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lpff_pkg::lpff_req_type req,
   input  wire lpff_pkg::lpff_cmd_type cmd,
   output lpff_pkg::lpff_sts_type    sts,
   output lpff_pkg::lpff_rsp_type    rsp,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall
);
   import lpff_pkg::*;

   localparam int unsigned AW = (FRAGMENT_BYTES > 1) ? $clog2(FRAGMENT_BYTES) : 1;

   logic [LPFF_DATA_W-1:0]  mem [FRAGMENT_BYTES];
   logic [LPFF_DATA_W-1:0]  rd_data_ff;

   logic [LPFF_COUNT_W-1:0] fill_ff, fill_in;
   logic [LPFF_COUNT_W-1:0] len_ff, len_in;
   logic                    more_ff, more_in;
   logic [LPFF_HDR_W-1:0]   hdr_idx_ff, hdr_idx_in;
   logic [LPFF_COUNT_W-1:0] ptr_ff, ptr_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   lpff_rsp_type            rsp_ff, rsp_in;
   logic [LPFF_WORD_W-1:0]  hdr_word;
   logic [LPFF_DATA_W-1:0]  hdr_byte;
   logic [LPFF_COUNT_W-1:0] fill_inc;

   assign fill_inc = fill_ff + LPFF_COUNT_W'(1);
   assign hdr_word = {{(LPFF_WORD_W-LPFF_COUNT_W-1){1'b0}}, len_ff, more_ff};

   always_comb begin
      case (hdr_idx_ff)
         2'd0:    hdr_byte = hdr_word[31:24];
         2'd1:    hdr_byte = hdr_word[23:16];
         2'd2:    hdr_byte = hdr_word[15:8];
         default: hdr_byte = hdr_word[7:0];
      endcase
   end

   assign sts.full     = (fill_ff == LPFF_COUNT_W'(FRAGMENT_BYTES - 1));
   assign sts.hdr_last = (hdr_idx_ff == LPFF_HDR_W'(3));
   assign sts.pay_last = ((ptr_ff + LPFF_COUNT_W'(1)) == len_ff);
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      fill_in      = fill_ff;
      len_in       = len_ff;
      more_in      = more_ff;
      hdr_idx_in   = hdr_idx_ff;
      ptr_in       = ptr_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (cmd.wr) begin
         fill_in = cmd.emit ? '0 : fill_inc;
      end
      if (cmd.emit) begin
         len_in     = fill_inc;
         more_in    = !req.message_last;
         hdr_idx_in = '0;
         ptr_in     = '0;
      end
      if (cmd.hdr_load) begin
         hdr_idx_in          = hdr_idx_ff + LPFF_HDR_W'(1);
         rsp_in.out_byte     = hdr_byte;
         rsp_in.is_header    = 1'b1;
         rsp_in.fragment_end = 1'b0;
         rsp_in.message_end  = 1'b0;
         rsp_valid_in        = 1'b1;
      end
      if (cmd.pay_load) begin
         ptr_in              = ptr_ff + LPFF_COUNT_W'(1);
         rsp_in.out_byte     = rd_data_ff;
         rsp_in.is_header    = 1'b0;
         rsp_in.fragment_end = sts.pay_last;
         rsp_in.message_end  = sts.pay_last && !more_ff;
         rsp_valid_in        = 1'b1;
      end
   end

   // read addr runs one step ahead so rd_data_ff holds mem[ptr_ff] on pay_load
   always_ff @(posedge clock) begin
      if (cmd.wr) begin
         mem[fill_ff[AW-1:0]] <= req.data_byte;
      end
      rd_data_ff <= mem[ptr_in[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff     <= len_in;
      more_ff    <= more_in;
      hdr_idx_ff <= hdr_idx_in;
      ptr_ff     <= ptr_in;
      rsp_ff     <= rsp_in;
   end

   assign rsp       = rsp_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

>>> hdl/lpff_ctrl.sv
// Controller of the framer: fill / header / payload sequencing.
// Depends on lpff_pkg; drives lpff_datapath through command signals.
`default_nettype none

module lpff_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   message_last,
   output logic                        req_stall,
   input  wire lpff_pkg::lpff_sts_type sts,
   output lpff_pkg::lpff_cmd_type      cmd
);
   import lpff_pkg::*;

   localparam logic [1:0] ST_FILL = 2'd0;
   localparam logic [1:0] ST_HDR  = 2'd1;
   localparam logic [1:0] ST_PAY  = 2'd2;

   logic [1:0] state_ff, state_in;

   assign req_stall = (state_ff != ST_FILL);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_FILL: begin
            if (req_valid) begin
               cmd.wr = 1'b1;
               if (message_last || sts.full) begin
                  cmd.emit = 1'b1;
                  state_in = ST_HDR;
               end
            end
         end
         ST_HDR: begin
            if (sts.out_free) begin
               cmd.hdr_load = 1'b1;
               if (sts.hdr_last) begin
                  state_in = ST_PAY;
               end
            end
         end
         ST_PAY: begin
            if (sts.out_free) begin
               cmd.pay_load = 1'b1;
               if (sts.pay_last) begin
                  state_in = ST_FILL;
               end
            end
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> hdl/length_prefixed_fragment_framer.sv
// The accept that closes a fragment moves the controller to its header state; the first
// header item is then loaded into the output register once that register is free.
// Throughput: one byte item accepted per cycle while filling; a fragment of L bytes then
// drains as 4 header and L payload items via the output register, input held off meanwhile.
// Reset is synchronous: clears fill count, state and output valid; buffer is not cleared.
// Depends on lpff_pkg, lpff_ctrl and lpff_datapath.
`default_nettype none

module length_prefixed_fragment_framer #(
   parameter int unsigned FRAGMENT_BYTES = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire lpff_pkg::lpff_req_type req,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output lpff_pkg::lpff_rsp_type      rsp
);
   import lpff_pkg::*;

   lpff_cmd_type cmd;
   lpff_sts_type sts;

   lpff_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .message_last (req.message_last),
      .req_stall    (req_stall),
      .sts          (sts),
      .cmd          (cmd)
   );

   lpff_datapath #(
      .FRAGMENT_BYTES (FRAGMENT_BYTES)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .cmd       (cmd),
      .sts       (sts),
      .rsp       (rsp),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall)
   );

endmodule

`default_nettype wire

>>> hdl/lpff_checker.sv
// Port-level checker for the framer, bound to the top level.
// Depends on lpff_pkg and length_prefixed_fragment_framer.
`default_nettype none

module lpff_checker (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   req_valid,
   input wire logic                   req_stall,
   input wire lpff_pkg::lpff_req_type req,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire lpff_pkg::lpff_rsp_type rsp
);
   import lpff_pkg::*;

   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("output valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled output item changed");

   a_header_no_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.is_header |-> !rsp.fragment_end && !rsp.message_end)
      else $error("header item flagged as end");

   a_msg_end_is_frag_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.message_end |-> rsp.fragment_end)
      else $error("message end without fragment end");

   a_last_closes_input: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req.message_last |=> req_stall)
      else $error("input open after last byte");

endmodule

bind length_prefixed_fragment_framer lpff_checker u_lpff_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req       (req),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp       (rsp)
);

`default_nettype wire

>>> dv/fragment_stream_checker.sv
// Checker for the length-prefixed fragment framer: watches both channels, predicts
// the framed output bytes of every accepted item and compares them in order.
// Depends on lpff_pkg.
module fragment_stream_checker #(
   parameter int unsigned FRAGMENT_BYTES = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_stall,
   input  wire lpff_pkg::lpff_req_type req,
   input  wire logic                   rsp_valid,
   input  wire logic                   rsp_stall,
   input  wire lpff_pkg::lpff_rsp_type rsp,
   output int                          mismatch_count,
   output int                          bytes_outstanding
);
   timeunit 1ns;
   timeprecision 1ps;
   import lpff_pkg::*;

   lpff_rsp_type            framed_bytes[$];
   logic [LPFF_DATA_W-1:0]  staged_bytes[FRAGMENT_BYTES];
   logic [LPFF_COUNT_W-1:0] fill;

   task automatic queue_fragment(input logic [LPFF_COUNT_W-1:0] len, input logic more);
      logic [LPFF_WORD_W-1:0] word;
      lpff_rsp_type           r;
      word = {{(LPFF_WORD_W-LPFF_COUNT_W-1){1'b0}}, len, more};
      for (int k = 3; k >= 0; k--) begin
         r.out_byte     = word[8*k +: 8];
         r.is_header    = 1'b1;
         r.fragment_end = 1'b0;
         r.message_end  = 1'b0;
         framed_bytes.push_back(r);
      end
      for (int i = 0; i < len; i++) begin
         r.out_byte     = staged_bytes[i];
         r.is_header    = 1'b0;
         r.fragment_end = (i == len - 1);
         r.message_end  = (i == len - 1) && !more;
         framed_bytes.push_back(r);
      end
   endtask

   task automatic frame_byte(input lpff_req_type item);
      logic [LPFF_COUNT_W-1:0] len;
      if (fill >= FRAGMENT_BYTES) fill = '0;
      staged_bytes[fill] = item.data_byte;
      fill = fill + LPFF_COUNT_W'(1);
      if (item.message_last) begin
         len  = fill;
         fill = '0;
         queue_fragment(len, 1'b0);
      end else if (fill >= FRAGMENT_BYTES) begin
         len  = fill;
         fill = '0;
         queue_fragment(len, 1'b1);
      end
   endtask

   task automatic check_byte(input lpff_rsp_type got);
      lpff_rsp_type want;
      if (framed_bytes.size() == 0) begin
         $error("output item %h with nothing expected", got);
         mismatch_count++;
      end else begin
         want = framed_bytes.pop_front();
         if (got.out_byte !== want.out_byte) begin
            $error("out_byte: expected %0h, got %0h", want.out_byte, got.out_byte);
            mismatch_count++;
         end
         if (got.is_header !== want.is_header) begin
            $error("is_header: expected %0b, got %0b", want.is_header, got.is_header);
            mismatch_count++;
         end
         if (got.fragment_end !== want.fragment_end) begin
            $error("fragment_end: expected %0b, got %0b", want.fragment_end,
                   got.fragment_end);
            mismatch_count++;
         end
         if (got.message_end !== want.message_end) begin
            $error("message_end: expected %0b, got %0b", want.message_end,
                   got.message_end);
            mismatch_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fill = '0;
         framed_bytes.delete();
      end else begin
         if (rsp_valid && !rsp_stall) check_byte(rsp);
         if (req_valid && !req_stall) frame_byte(req);
      end
      bytes_outstanding = framed_bytes.size();
   end

endmodule

>>> dv/tb.sv
// Top of the framer testbench: clock, reset, byte-stream stimulus with random idling
// and output stalls, and the verdict. Depends on lpff_pkg, the framer and
// fragment_stream_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lpff_pkg::*;

   localparam int unsigned FRAG_BYTES  = 32;
   localparam int unsigned ITEM_TARGET = 370;
   localparam int unsigned QUIET_FROM  = 310;
   localparam int unsigned HOLD_POINT  = 180;

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   lpff_req_type req       = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   lpff_rsp_type rsp;

   int          mismatch_count;
   int          bytes_outstanding;
   bit          idle_on = 1'b1;
   bit          held    = 1'b0;
   int unsigned bytes_sent;
   int unsigned msg_len;

   always #5 clock = ~clock;

   length_prefixed_fragment_framer #(.FRAGMENT_BYTES(FRAG_BYTES)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   fragment_stream_checker #(.FRAGMENT_BYTES(FRAG_BYTES)) u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req               (req),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp               (rsp),
      .mismatch_count    (mismatch_count),
      .bytes_outstanding (bytes_outstanding)
   );

   task automatic send_byte(input logic [LPFF_DATA_W-1:0] b, input logic last);
      int gap;
      @(negedge clock);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req.data_byte     <= b;
      req.message_last  <= last;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_message(input int unsigned len);
      for (int unsigned i = 0; i < len; i++)
         send_byte(LPFF_DATA_W'($urandom_range(0, 255)), i == len - 1);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (bytes_outstanding != 0) @(negedge clock);
   endtask

   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r < 4) return $urandom_range(1, 6);
      if (r < 6) return $urandom_range(FRAG_BYTES - 1, FRAG_BYTES + 1);
      if (r < 7) return $urandom_range(2 * FRAG_BYTES - 1, 2 * FRAG_BYTES + 1);
      return $urandom_range(1, FRAG_BYTES + 8);
   endfunction

   // output stalls in bursts
   initial begin
      forever begin
         @(negedge clock);
         if (idle_on && $urandom_range(0, 5) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 8)) @(negedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

   initial begin
      repeat (6) @(negedge clock);
      reset <= 1'b0;

      // single-byte messages at the data extremes, then short multi-byte ones
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      send_byte(8'h01, 1'b0);
      send_byte(8'h80, 1'b0);
      send_byte(8'h7F, 1'b1);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b1);
      drain();

      // exact fill on last byte, fill mid-message, two full fragments, one short
      send_message(FRAG_BYTES);
      send_message(FRAG_BYTES + 1);
      send_message(2 * FRAG_BYTES);
      send_message(FRAG_BYTES - 1);

      while (bytes_sent < ITEM_TARGET) begin
         if (bytes_sent >= QUIET_FROM) idle_on = 1'b0;
         if (!held && bytes_sent >= HOLD_POINT) begin
            drain();
            held = 1'b1;
         end
         msg_len = pick_length();
         if (msg_len > ITEM_TARGET - bytes_sent) msg_len = ITEM_TARGET - bytes_sent;
         send_message(msg_len);
      end
      idle_on = 1'b0;
      drain();
      repeat (20) @(negedge clock);

      if (mismatch_count == 0 && bytes_outstanding == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

>>> files.f
hdl/lpff_pkg.sv
hdl/lpff_datapath.sv
hdl/lpff_ctrl.sv
hdl/length_prefixed_fragment_framer.sv
hdl/lpff_checker.sv
dv/fragment_stream_checker.sv
dv/tb.sv
